>>> rtl/mbt_pkg.sv
// Shared types and constants for the multiset bag table.
`timescale 1ns / 1ps
package mbt_pkg;

  localparam int DefaultCapacity = 64;
  localparam int ValueW          = 32;
  localparam int CmdW            = 3;
  localparam int OutCntW         = 7;
  localparam int InDataW         = 32;
  localparam int OutDataW        = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD       = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_FREQUENCY = 3'd2,
    CMD_CONTAINS  = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic                success;
    logic [OutCntW-1:0]  match_count;
    logic [OutCntW-1:0]  size_after;
  } result_t;

endpackage

>>> rtl/multiset_bag_table_top.sv
// Top level of the multiset bag table: input register, command logic and result register.
//
//  Channel  Direction  tdata                                   tuser
//  s_axis   in         item_value[31:0]                        command[2:0]
//  m_axis   out        success[0] match_count[7:1] size[14:8]  -
//
// One item per cycle unless m_axis stalls; an item passes the input and result registers.
// All entries are compared in parallel, so the match vector, priority encoder and
// population count settle each command combinationally between the two registers.
// Reset clears the valid flags and entry count; entries are rewritten before they are read.
// A stalled result holds the input register, which in turn drops s_axis_tready.
`timescale 1ns / 1ps
module multiset_bag_table_top
  import mbt_pkg::*;
#(
  parameter int BAG_CAPACITY = DefaultCapacity,
  localparam int IdxW = (BAG_CAPACITY > 1) ? $clog2(BAG_CAPACITY) : 1,
  localparam int CntW = $clog2(BAG_CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // item_value[31:0]
  input  logic [CmdW-1:0]     s_axis_tuser,   // command[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // success, match_count[6:0], size_after[6:0], pad
);

  localparam logic [CntW-1:0] CapC = CntW'(BAG_CAPACITY);

  logic                    in_vld_q;
  logic [CmdW-1:0]         cmd_q;
  logic [ValueW-1:0]       val_q;
  logic                    out_vld_q;
  result_t                 res_q, res_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    advance, fire;
  logic                    we;
  logic [IdxW-1:0]         waddr, last_idx;
  logic [ValueW-1:0]       wdata, last_data;
  logic [BAG_CAPACITY-1:0] match;
  logic                    found;
  logic [IdxW-1:0]         first;
  logic [CntW-1:0]         match_cnt;

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = advance && in_vld_q;
  assign s_axis_tready = !in_vld_q || advance;
  assign last_idx      = IdxW'(count_q - CntW'(1));

  mbt_cells #(
    .BAG_CAPACITY(BAG_CAPACITY)
  ) u_cells (
    .clk_i      (clk_i),
    .we_i       (we),
    .waddr_i    (waddr),
    .wdata_i    (wdata),
    .count_i    (count_q),
    .value_i    (val_q),
    .last_idx_i (last_idx),
    .match_o    (match),
    .last_data_o(last_data)
  );

  mbt_reduce #(
    .BAG_CAPACITY(BAG_CAPACITY)
  ) u_reduce (
    .match_i(match),
    .found_o(found),
    .first_o(first),
    .count_o(match_cnt)
  );

  always_comb begin
    count_d = count_q;
    we      = 1'b0;
    waddr   = IdxW'(count_q);
    wdata   = val_q;
    res_d.success = 1'b0;
    unique case (cmd_e'(cmd_q))
      CMD_ADD: begin
        if (count_q < CapC) begin
          we            = fire;
          count_d       = count_q + CntW'(1);
          res_d.success = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          we            = fire;
          waddr         = first;
          wdata         = last_data;
          count_d       = count_q - CntW'(1);
          res_d.success = 1'b1;
        end
      end
      CMD_FREQUENCY, CMD_CONTAINS: begin
        res_d.success = found;
      end
      CMD_CLEAR: begin
        count_d       = '0;
        res_d.success = 1'b1;
      end
      default: begin
      end
    endcase
    res_d.match_count = OutCntW'(match_cnt);
    res_d.size_after  = OutCntW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q <= s_axis_tuser;
      val_q <= s_axis_tdata[ValueW-1:0];
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, res_q.size_after, res_q.match_count, res_q.success};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count exceeds capacity");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cmd_e'(cmd_q) == CMD_ADD && count_q < CapC |=> count_q == $past(count_q) + CntW'(1))
    else $error("add with room did not grow the bag");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cmd_e'(cmd_q) == CMD_REMOVE && found |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove of a present value did not shrink the bag");

  a_matches_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> match_cnt <= count_q)
    else $error("match count exceeds live entries");

endmodule

>>> rtl/mbt_cells.sv
// Entry storage with one equality comparator per entry and a read port for the last entry.
`timescale 1ns / 1ps
module mbt_cells
  import mbt_pkg::*;
#(
  parameter int BAG_CAPACITY = DefaultCapacity,
  localparam int IdxW = (BAG_CAPACITY > 1) ? $clog2(BAG_CAPACITY) : 1,
  localparam int CntW = $clog2(BAG_CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IdxW-1:0]         waddr_i,
  input  logic [ValueW-1:0]       wdata_i,
  input  logic [CntW-1:0]         count_i,
  input  logic [ValueW-1:0]       value_i,
  input  logic [IdxW-1:0]         last_idx_i,
  output logic [BAG_CAPACITY-1:0] match_o,
  output logic [ValueW-1:0]       last_data_o
);

  logic [ValueW-1:0] entry_q [BAG_CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q[waddr_i] <= wdata_i;
    end
  end

  for (genvar i = 0; i < BAG_CAPACITY; i++) begin : g_cell
    assign match_o[i] = (CntW'(i) < count_i) && (entry_q[i] == value_i);
  end

  assign last_data_o = entry_q[last_idx_i];

endmodule

>>> rtl/mbt_reduce.sv
// Priority encoder and population count over the match vector.
`timescale 1ns / 1ps
module mbt_reduce
  import mbt_pkg::*;
#(
  parameter int BAG_CAPACITY = DefaultCapacity,
  localparam int IdxW = (BAG_CAPACITY > 1) ? $clog2(BAG_CAPACITY) : 1,
  localparam int CntW = $clog2(BAG_CAPACITY + 1)
) (
  input  logic [BAG_CAPACITY-1:0] match_i,
  output logic                    found_o,
  output logic [IdxW-1:0]         first_o,
  output logic [CntW-1:0]         count_o
);

  always_comb begin
    first_o = '0;
    for (int i = BAG_CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        first_o = IdxW'(i);
      end
    end
  end

  always_comb begin
    count_o = '0;
    for (int i = 0; i < BAG_CAPACITY; i++) begin
      count_o = count_o + CntW'(match_i[i]);
    end
  end

  assign found_o = |match_i;

endmodule

>>> tb/sv/multiset_bag_table_top_test.sv
// Self-checking stream testbench for the multiset bag table with random idling and backpressure.
`timescale 1ns / 1ps
module multiset_bag_table_top_test;
  import mbt_pkg::*;

  localparam logic [CmdW-1:0] CmdSpareFirst = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareLast  = 3'd7;
  localparam int unsigned     StallLongest  = 18;
  localparam int unsigned     HoldOffCycles = 400;
  localparam int unsigned     HoldOffAt     = 300;
  localparam int unsigned     StuckLimit    = 4000;
  localparam int unsigned     RandomItems   = 2000;
  localparam int unsigned     PrintLimit    = 20;

  typedef struct {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
  } bag_cmd_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  bag_cmd_t    pending_cmds[$];
  result_t     expected_results[$];
  logic [ValueW-1:0] bag_slots[DefaultCapacity];
  int unsigned bag_fill;
  int unsigned total_cmds;
  int unsigned accepted_cmds;
  int unsigned results_seen;
  int unsigned err_cnt;
  int unsigned send_gap;
  bit          send_burst;
  int unsigned recv_stall;
  bit          recv_burst;
  int unsigned stuck_cycles;

  multiset_bag_table_top #(
    .BAG_CAPACITY(DefaultCapacity)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // item_value[31:0]
    .s_axis_tuser  (s_axis_tuser),   // command[2:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // success, match_count[6:0], size_after[6:0], pad
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < PrintLimit) $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic result_t apply_bag_cmd(input logic [CmdW-1:0] cmd,
                                            input logic [ValueW-1:0] value);
    result_t     res;
    int unsigned hits;
    int          first;
    hits  = 0;
    first = -1;
    for (int i = 0; i < bag_fill; i++) begin
      if (bag_slots[i] == value) begin
        if (first < 0) first = i;
        hits++;
      end
    end
    res.success = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (bag_fill < DefaultCapacity) begin
          bag_slots[bag_fill] = value;
          bag_fill++;
          res.success = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (first >= 0) begin
          bag_fill--;
          bag_slots[first] = bag_slots[bag_fill];
          res.success = 1'b1;
        end
      end
      CMD_FREQUENCY, CMD_CONTAINS: res.success = (hits != 0);
      CMD_CLEAR: begin
        bag_fill    = 0;
        res.success = 1'b1;
      end
      default: ;
    endcase
    res.match_count = OutCntW'(hits);
    res.size_after  = OutCntW'(bag_fill);
    return res;
  endfunction

  function automatic logic [ValueW-1:0] pick_value(input logic [ValueW-1:0] pool[$]);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic queue_cmd(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
    bag_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    pending_cmds.insert(pending_cmds.size(), c);
    total_cmds++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bag_cmd_t c;
    bit       busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      = 0;
      send_burst    = 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(),
                                apply_bag_cmd(s_axis_tuser, s_axis_tdata));
        accepted_cmds++;
        busy = 0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          c = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= c.value;
          s_axis_tuser  <= c.cmd;
          if (accepted_cmds % 150 == 0) send_burst = ($urandom_range(0, 2) == 0);
          send_gap = send_burst ? 0 : $urandom_range(0, StallLongest);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    = 0;
      recv_burst    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[0] !== want.success)
            report_mismatch($sformatf("result %0d success %b, want %b",
                                      results_seen, m_axis_tdata[0], want.success));
          if (m_axis_tdata[7:1] !== want.match_count)
            report_mismatch($sformatf("result %0d match_count %0d, want %0d",
                                      results_seen, m_axis_tdata[7:1], want.match_count));
          if (m_axis_tdata[14:8] !== want.size_after)
            report_mismatch($sformatf("result %0d size_after %0d, want %0d",
                                      results_seen, m_axis_tdata[14:8], want.size_after));
        end
        if (results_seen % 170 == 0) recv_burst = ($urandom_range(0, 2) == 0);
        recv_stall = recv_burst ? 0 : $urandom_range(0, StallLongest);
        if (results_seen == HoldOffAt) recv_stall = HoldOffCycles;
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_axis_tready <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [ValueW-1:0] pool[$];
    int unsigned       block_len;
    int unsigned       kind;
    int unsigned       roll;
    int unsigned       pool_len;
    logic [CmdW-1:0]   cmd;

    // Empty bag first, then the value extremes, duplicates, absent values, spare codes and a clear.
    queue_cmd(CMD_REMOVE,    32'h0000_0000);
    queue_cmd(CMD_CONTAINS,  32'h0000_0000);
    queue_cmd(CMD_FREQUENCY, 32'h8000_0000);
    queue_cmd(CMD_ADD,       32'h8000_0000);
    queue_cmd(CMD_ADD,       32'h7FFF_FFFF);
    queue_cmd(CMD_ADD,       32'h0000_0000);
    queue_cmd(CMD_ADD,       32'hFFFF_FFFF);
    queue_cmd(CMD_ADD,       32'hFFFF_FFFF);
    queue_cmd(CMD_FREQUENCY, 32'hFFFF_FFFF);
    queue_cmd(CMD_CONTAINS,  32'h8000_0000);
    queue_cmd(CMD_CONTAINS,  32'h7FFF_FFFE);
    queue_cmd(CMD_REMOVE,    32'h0000_0001);
    queue_cmd(CMD_REMOVE,    32'h8000_0000);
    queue_cmd(CMD_FREQUENCY, 32'hFFFF_FFFF);
    queue_cmd(CMD_REMOVE,    32'hFFFF_FFFF);
    for (cmd = CmdSpareFirst; cmd <= CmdSpareLast && cmd >= CmdSpareFirst; cmd++)
      queue_cmd(cmd, 32'h7FFF_FFFF);
    queue_cmd(CMD_CLEAR,     32'hFFFF_FFFF);
    queue_cmd(CMD_CONTAINS,  32'h0000_0000);
    queue_cmd(CMD_ADD,       32'h5555_5555);
    queue_cmd(CMD_ADD,       32'hAAAA_AAAA);
    queue_cmd(CMD_REMOVE,    32'hAAAA_AAAA);
    queue_cmd(CMD_FREQUENCY, 32'h5555_5555);

    // Random blocks: filling, draining, mixed, and mostly one-value runs that can reach a full bag of equals.
    while (total_cmds < RandomItems) begin
      block_len = $urandom_range(40, 160);
      kind      = $urandom_range(0, 3);
      pool_len  = (kind == 3) ? 1 : $urandom_range(1, 8);
      pool.delete();
      for (int i = 0; i < pool_len; i++) begin
        case ($urandom_range(0, 7))
          0:       pool.insert(pool.size(), 32'h8000_0000);
          1:       pool.insert(pool.size(), 32'h7FFF_FFFF);
          2:       pool.insert(pool.size(), 32'hFFFF_FFFF);
          3:       pool.insert(pool.size(), 32'h0000_0000);
          default: pool.insert(pool.size(), $urandom);
        endcase
      end
      for (int n = 0; n < block_len; n++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0:       cmd = (roll < 75) ? CMD_ADD : (roll < 85) ? CMD_REMOVE :
                         (roll < 91) ? CMD_FREQUENCY : (roll < 96) ? CMD_CONTAINS :
                         (roll < 99) ? CmdW'(CmdSpareFirst + $urandom_range(0, 2)) :
                         CMD_CLEAR;
          1:       cmd = (roll < 15) ? CMD_ADD : (roll < 80) ? CMD_REMOVE :
                         (roll < 88) ? CMD_FREQUENCY : (roll < 95) ? CMD_CONTAINS :
                         (roll < 98) ? CmdW'(CmdSpareFirst + $urandom_range(0, 2)) :
                         CMD_CLEAR;
          2:       cmd = (roll < 35) ? CMD_ADD : (roll < 65) ? CMD_REMOVE :
                         (roll < 78) ? CMD_FREQUENCY : (roll < 90) ? CMD_CONTAINS :
                         (roll < 96) ? CmdW'(CmdSpareFirst + $urandom_range(0, 2)) :
                         CMD_CLEAR;
          default: cmd = (roll < 85) ? CMD_ADD : (roll < 90) ? CMD_REMOVE :
                         (roll < 95) ? CMD_FREQUENCY : CMD_CONTAINS;
        endcase
        queue_cmd(cmd, pick_value(pool));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds != total_cmds || expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
